// ----- src/wga_pkg.sv -----
// Shared types, sizes and helpers for the weighted Gram matrix accumulator.
// Used by wga_front, wga_queue, wga_back and weighted_gram_accumulate.
package wga_pkg;

  // Matrix size and field widths
  localparam int MAX_FEATURES = 8;
  localparam int IDX_W        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int DIM_W        = $clog2(MAX_FEATURES + 1);
  localparam int PAIR_COUNT   = (MAX_FEATURES * (MAX_FEATURES + 1)) / 2;
  localparam int SLOT_W       = $clog2(PAIR_COUNT);

  localparam int INDEX_W  = 3;
  localparam int CMP_W    = INDEX_W + 1;
  localparam int CFG_W    = 4;
  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int SQ_W     = 2 * VALUE_W;
  localparam int PROD_W   = 48;
  localparam int GRAM_W   = 64;
  localparam int ROWCOL_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued command: snapshot of the sample plus what to do with it
  typedef struct packed {
    logic [MAX_FEATURES-1:0][VALUE_W-1:0] x;
    logic [WEIGHT_W-1:0]                  weight;
    logic [DIM_W-1:0]                     dim;
    logic                                 complete;
    logic                                 flush;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN,
    BK_EMIT
  } back_state_t;

  // Row-major position of pair (i, j), i <= j, in the full upper triangle
  function automatic logic [SLOT_W-1:0] pair_slot(input logic [IDX_W-1:0] i,
                                                 input logic [IDX_W-1:0] j);
    int ii;
    int jj;
    int base;
    ii   = int'(i);
    jj   = int'(j);
    base = ii * MAX_FEATURES - ((ii * (ii - 1)) >>> 1);
    return SLOT_W'(base + jj - ii);
  endfunction

endpackage

// ----- src/wga_front.sv -----
// Front end: holds the dimension register and the sample buffer, accepts
// feature words and queues a command when a sample completes or data ends.
// Depends on wga_pkg.
module wga_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [wga_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wga_pkg::INDEX_W-1:0] feature_index,
  input  logic [wga_pkg::VALUE_W-1:0] feature_value,
  input  logic [wga_pkg::WEIGHT_W-1:0] sample_weight,
  input  logic                        end_of_data,
  input  logic                        q_full,
  output logic                        q_push,
  output wga_pkg::cmd_t               q_cmd
);

  logic [wga_pkg::CFG_W-1:0]   active_features;
  logic [wga_pkg::VALUE_W-1:0] sample_buffer [wga_pkg::MAX_FEATURES];
  logic [wga_pkg::DIM_W-1:0]   dim;
  logic                        accept;
  logic                        store;
  logic                        complete;

  // Hold the dimension register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_features <= wga_pkg::CFG_RESET;
    end else if (cfg_we) begin
      active_features <= cfg_wdata;
    end
  end

  // Clamp the dimension to 1..MAX_FEATURES
  always_comb begin
    if (active_features == '0) begin
      dim = wga_pkg::DIM_W'(1);
    end else if (active_features > wga_pkg::CFG_W'(wga_pkg::MAX_FEATURES)) begin
      dim = wga_pkg::DIM_W'(wga_pkg::MAX_FEATURES);
    end else begin
      dim = wga_pkg::DIM_W'(active_features);
    end
  end

  // Classify the incoming word
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign store    = {1'b0, feature_index} < wga_pkg::CMP_W'(wga_pkg::MAX_FEATURES);
  assign complete = {1'b0, feature_index} == (wga_pkg::CMP_W'(dim) - 1'b1);
  assign q_push   = accept && (complete || end_of_data);

  // Store the feature value
  always_ff @(posedge clk) begin
    if (accept && store) begin
      sample_buffer[feature_index[wga_pkg::IDX_W-1:0]] <= feature_value;
    end
  end

  // Build the command: buffer snapshot with this word's value merged in
  always_comb begin
    for (int k = 0; k < wga_pkg::MAX_FEATURES; k++) begin
      if (store && (feature_index[wga_pkg::IDX_W-1:0] == wga_pkg::IDX_W'(k))) begin
        q_cmd.x[k] = feature_value;
      end else begin
        q_cmd.x[k] = sample_buffer[k];
      end
    end
    q_cmd.weight   = sample_weight;
    q_cmd.dim      = dim;
    q_cmd.complete = complete;
    q_cmd.flush    = end_of_data;
  end

endmodule

// ----- src/wga_queue.sv -----
// Short command queue between the front end and the accumulate/emit engine.
// Depends on wga_pkg.
module wga_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wga_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output wga_pkg::cmd_t pop_cmd
);

  wga_pkg::cmd_t              slots [wga_pkg::QUEUE_DEPTH];
  logic [wga_pkg::QPTR_W-1:0] wr_ptr;
  logic [wga_pkg::QPTR_W-1:0] rd_ptr;
  logic [wga_pkg::QCNT_W-1:0] count;

  assign full     = count == wga_pkg::QCNT_W'(wga_pkg::QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign pop_cmd  = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == wga_pkg::QPTR_W'(wga_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == wga_pkg::QPTR_W'(wga_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/wga_back.sv -----
// Back end: walks the active upper triangle with one pipelined MAC, keeps
// the pair accumulators in a memory with valid bits, and emits the matrix.
// Depends on wga_pkg.
module wga_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  wga_pkg::cmd_t                       q_cmd,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wga_pkg::ROWCOL_W-1:0]        row,
  output logic [wga_pkg::ROWCOL_W-1:0]        col,
  output logic signed [wga_pkg::GRAM_W-1:0]   gram_value,
  output logic                                last_entry
);

  wga_pkg::back_state_t state;
  wga_pkg::back_state_t state_next;

  // Current command
  logic [wga_pkg::MAX_FEATURES-1:0][wga_pkg::VALUE_W-1:0] cur_x;
  logic [wga_pkg::WEIGHT_W-1:0] cur_w;
  logic [wga_pkg::DIM_W-1:0]    cur_dim;
  logic                         cur_flush;

  // Pair walk
  logic [wga_pkg::IDX_W-1:0]  pi;
  logic [wga_pkg::IDX_W-1:0]  pj;
  logic                       row_end;
  logic                       pair_last;
  logic                       mac_issue;
  logic                       emit_issue;
  logic                       rd_en;
  logic [wga_pkg::SLOT_W-1:0] rd_slot;

  // Accumulator memory
  logic [wga_pkg::GRAM_W-1:0]     acc_mem [wga_pkg::PAIR_COUNT];
  logic [wga_pkg::PAIR_COUNT-1:0] acc_vld;
  logic [wga_pkg::GRAM_W-1:0]     rd_data;
  logic                           rd_vld;
  logic signed [wga_pkg::GRAM_W-1:0] rd_value;

  // MAC pipeline
  logic                              s1_v;
  logic [wga_pkg::SLOT_W-1:0]        s1_slot;
  logic signed [wga_pkg::SQ_W-1:0]   s1_prod;
  logic                              s2_v;
  logic [wga_pkg::SLOT_W-1:0]        s2_slot;
  logic signed [wga_pkg::PROD_W-1:0] s2_prod;
  logic signed [wga_pkg::GRAM_W-1:0] s2_acc;
  logic signed [wga_pkg::PROD_W-1:0] mul2;
  logic signed [wga_pkg::GRAM_W:0]   sum_wide;
  logic signed [wga_pkg::GRAM_W-1:0] sum_sat;

  // Emission
  logic                         rd_pend;
  logic [wga_pkg::IDX_W-1:0]    rd_row;
  logic [wga_pkg::IDX_W-1:0]    rd_col;
  logic                         rd_last;

  assign row_end   = wga_pkg::DIM_W'(pj) == (cur_dim - 1'b1);
  assign pair_last = row_end && (wga_pkg::DIM_W'(pi) == (cur_dim - 1'b1));
  assign rd_en     = mac_issue || emit_issue;
  assign rd_slot   = wga_pkg::pair_slot(pi, pj);
  assign rd_value  = rd_vld ? $signed(rd_data) : '0;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wga_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence commands: accumulate, drain, then emit on flush
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mac_issue  = 1'b0;
    emit_issue = 1'b0;
    unique case (state)
      wga_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_cmd.complete ? wga_pkg::BK_MAC : wga_pkg::BK_EMIT;
        end
      end
      wga_pkg::BK_MAC: begin
        mac_issue = 1'b1;
        if (pair_last) begin
          state_next = wga_pkg::BK_DRAIN;
        end
      end
      wga_pkg::BK_DRAIN: begin
        if (!s1_v && !s2_v) begin
          state_next = cur_flush ? wga_pkg::BK_EMIT : wga_pkg::BK_IDLE;
        end
      end
      wga_pkg::BK_EMIT: begin
        if (!rd_pend && (!out_valid || out_ready)) begin
          emit_issue = 1'b1;
          if (pair_last) begin
            state_next = wga_pkg::BK_IDLE;
          end
        end
      end
      default: state_next = wga_pkg::BK_IDLE;
    endcase
  end

  // Latch the popped command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_x     <= q_cmd.x;
      cur_w     <= q_cmd.weight;
      cur_dim   <= q_cmd.dim;
      cur_flush <= q_cmd.flush;
    end
  end

  // Advance the pair walk; wrap to the origin after the last pair
  always_ff @(posedge clk) begin
    if (rst) begin
      pi <= '0;
      pj <= '0;
    end else if (rd_en) begin
      if (pair_last) begin
        pi <= '0;
        pj <= '0;
      end else if (row_end) begin
        pi <= pi + 1'b1;
        pj <= pi + 1'b1;
      end else begin
        pj <= pj + 1'b1;
      end
    end
  end

  // Saturating add of the weighted product to the accumulator
  assign mul2     = s1_prod * $signed({1'b0, cur_w});
  assign sum_wide = {s2_acc[wga_pkg::GRAM_W-1], s2_acc}
                  + {{(wga_pkg::GRAM_W + 1 - wga_pkg::PROD_W){s2_prod[wga_pkg::PROD_W-1]}},
                     s2_prod};

  always_comb begin
    if (sum_wide[wga_pkg::GRAM_W] != sum_wide[wga_pkg::GRAM_W-1]) begin
      sum_sat = sum_wide[wga_pkg::GRAM_W] ? {1'b1, {(wga_pkg::GRAM_W - 1){1'b0}}}
                                          : {1'b0, {(wga_pkg::GRAM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[wga_pkg::GRAM_W-1:0];
    end
  end

  // Accumulator memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (s2_v) begin
      acc_mem[s2_slot] <= sum_sat;
    end
    if (rd_en) begin
      rd_data <= acc_mem[rd_slot];
      rd_vld  <= acc_vld[rd_slot];
    end
  end

  // Mark written entries; drop all of them once the last entry is read out
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (emit_issue && pair_last) begin
      acc_vld <= '0;
    end else if (s2_v) begin
      acc_vld[s2_slot] <= 1'b1;
    end
  end

  // MAC pipeline data
  always_ff @(posedge clk) begin
    if (mac_issue) begin
      s1_prod <= $signed(cur_x[pi]) * $signed(cur_x[pj]);
      s1_slot <= rd_slot;
    end
    s2_prod <= mul2;
    s2_acc  <= rd_value;
    s2_slot <= s1_slot;
  end

  // MAC pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= mac_issue;
      s2_v <= s1_v;
    end
  end

  // Track the outstanding emission read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= emit_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_issue) begin
      rd_row  <= pi;
      rd_col  <= pj;
      rd_last <= pair_last;
    end
  end

  // Output register: load the read word, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      row        <= wga_pkg::ROWCOL_W'(rd_row);
      col        <= wga_pkg::ROWCOL_W'(rd_col);
      gram_value <= rd_value;
      last_entry <= rd_last;
    end
  end

endmodule

// ----- src/weighted_gram_accumulate.sv -----
// Top level of the weighted Gram matrix accumulator (upper triangle of X'WX).
// Depends on wga_pkg, wga_front, wga_queue and wga_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------
//   cfg      | cfg_we                    | cfg_wdata (active_features)
//   in       | in_valid / in_ready       | feature_index, feature_value,
//            |                           | sample_weight, end_of_data
//   out      | out_valid / out_ready     | row, col, gram_value, last_entry
//
// A word that completes a sample is served by the engine in order: a queue pop,
// one MAC pass per pair of the active upper triangle, then a drain of the MAC
// pipeline. Emission does not issue a new accumulator read while one is
// outstanding, and holds while the output register is full and out_ready is
// low.
// rst is synchronous; it clears the valid bits of all accumulators at once.
// in_ready drops only while the two-entry command queue is full.
module weighted_gram_accumulate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wga_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wga_pkg::INDEX_W-1:0]         feature_index,
  input  logic signed [wga_pkg::VALUE_W-1:0]  feature_value,
  input  logic [wga_pkg::WEIGHT_W-1:0]        sample_weight,
  input  logic                                end_of_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wga_pkg::ROWCOL_W-1:0]        row,
  output logic [wga_pkg::ROWCOL_W-1:0]        col,
  output logic signed [wga_pkg::GRAM_W-1:0]   gram_value,
  output logic                                last_entry
);

  wga_pkg::cmd_t push_cmd;
  wga_pkg::cmd_t pop_cmd;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_nonempty;

  wga_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .sample_weight (sample_weight),
    .end_of_data   (end_of_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  wga_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_cmd  (pop_cmd)
  );

  wga_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_nonempty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row        (row),
    .col        (col),
    .gram_value (gram_value),
    .last_entry (last_entry)
  );

  // Emitted entries stay in the upper triangle
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (col >= row))
    else $error("emitted entry below the diagonal");

  // The final entry sits on the diagonal
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && last_entry) |-> (row == col))
    else $error("last entry is off the diagonal");

  // A pop never happens on an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_nonempty)
    else $error("command popped from empty queue");

  // Nothing is emitted right after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for weighted_gram_accumulate: directed and random feature words.
// A local X'WX predictor supplies the expected upper-triangle entries at each end of data.
// Depends on wga_pkg and the weighted_gram_accumulate RTL.
module testbench;

  localparam int MAXF          = wga_pkg::MAX_FEATURES;
  localparam int RANDOM_WORDS  = 345;
  localparam int SETTLE_CYCLES = 200;
  localparam int TIMEOUT_TIME  = 40_000_000;
  localparam int REPORT_LIMIT  = 10;

  localparam longint SUM_MAX = longint'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam longint SUM_MIN = longint'(64'h8000_0000_0000_0000);

  typedef struct {
    logic [wga_pkg::ROWCOL_W-1:0]      row;
    logic [wga_pkg::ROWCOL_W-1:0]      col;
    logic signed [wga_pkg::GRAM_W-1:0] value;
    logic                              last;
  } gram_entry_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [wga_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [wga_pkg::INDEX_W-1:0] feature_index;
  logic signed [wga_pkg::VALUE_W-1:0] feature_value;
  logic [wga_pkg::WEIGHT_W-1:0] sample_weight;
  logic end_of_data;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [wga_pkg::ROWCOL_W-1:0] row;
  logic [wga_pkg::ROWCOL_W-1:0] col;
  logic signed [wga_pkg::GRAM_W-1:0] gram_value;
  logic last_entry;

  // Predictor state
  logic [wga_pkg::CFG_W-1:0]   dim_setting;
  logic [wga_pkg::VALUE_W-1:0] feature_buf [MAXF];
  logic [MAXF-1:0]             feature_written;
  longint                      pair_acc [MAXF][MAXF];

  gram_entry_t expected_entries [$];
  gram_entry_t next_entry;
  int  fail_count  = 0;
  int  words_sent  = 0;
  int  ready_hold  = 0;
  bit  steady      = 1'b0;

  weighted_gram_accumulate dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .sample_weight (sample_weight),
    .end_of_data   (end_of_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .row           (row),
    .col           (col),
    .gram_value    (gram_value),
    .last_entry    (last_entry)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none during a steady stretch
  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [wga_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [wga_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Register value 0 means one feature, anything above the maximum means the maximum
  function automatic int dim_in_use();
    if (dim_setting == 0) return 1;
    if (int'(dim_setting) > MAXF) return MAXF;
    return int'(dim_setting);
  endfunction

  function automatic longint saturating_add(longint acc, longint p);
    longint s;
    s = acc + p;
    if (p > 0 && s < acc) return SUM_MAX;
    if (p < 0 && s > acc) return SUM_MIN;
    return s;
  endfunction

  // Steer away from a completion that would read a never-written feature
  function automatic logic [wga_pkg::INDEX_W-1:0] safe_index(int idx, int m);
    logic [MAXF-1:0] need;
    need = (MAXF'(1) << (m - 1)) - MAXF'(1);
    if (idx == m - 1 && (feature_written & need) != need) return '0;
    return 3'(idx);
  endfunction

  // Apply one accepted word to the predictor and queue the entries it emits
  function automatic void accumulate_word(logic [wga_pkg::INDEX_W-1:0] idx,
                                          logic [wga_pkg::VALUE_W-1:0] val,
                                          logic [wga_pkg::WEIGHT_W-1:0] w,
                                          logic eod);
    int m;
    longint p;
    gram_entry_t e;
    m = dim_in_use();
    feature_buf[idx] = val;
    feature_written[idx] = 1'b1;
    if (int'(idx) == m - 1) begin
      for (int i = 0; i < m; i++) begin
        for (int j = i; j < m; j++) begin
          p = longint'(signed'(feature_buf[i])) * longint'(signed'(feature_buf[j]))
              * longint'({48'd0, w});
          pair_acc[i][j] = saturating_add(pair_acc[i][j], p);
        end
      end
    end
    if (eod) begin
      for (int i = 0; i < m; i++) begin
        for (int j = i; j < m; j++) begin
          e.row   = 3'(i);
          e.col   = 3'(j);
          e.value = pair_acc[i][j];
          e.last  = (i == m - 1) && (j == m - 1);
          expected_entries.push_back(e);
        end
      end
      for (int i = 0; i < MAXF; i++)
        for (int j = 0; j < MAXF; j++)
          pair_acc[i][j] = 0;
    end
  endfunction

  // Send one feature word; returns right after the edge that accepts it
  task automatic send_word(logic [wga_pkg::INDEX_W-1:0] idx,
                           logic [wga_pkg::VALUE_W-1:0] val,
                           logic [wga_pkg::WEIGHT_W-1:0] w,
                           logic eod);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    feature_index <= idx;
    feature_value <= val;
    sample_weight <= w;
    end_of_data   <= eod;
    do @(posedge clk); while (!in_ready);
    accumulate_word(idx, val, w, eod);
    words_sent++;
  endtask

  // Hold the sender until every expected entry is out, then let the engine settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dimension(logic [wga_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_setting = v;
  endtask

  // A full eight-feature sample at the reset dimension, then a sample with stale features
  task automatic test_full_dimension();
    logic [wga_pkg::VALUE_W-1:0] vals [MAXF];
    vals = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h0100, 16'hFF00, 16'h5555};
    for (int f = 0; f < MAXF - 1; f++)
      send_word(3'(f), vals[f], pick_weight(), 1'b0);
    send_word(3'(MAXF - 1), vals[MAXF - 1], 16'hFFFF, 1'b0);
    send_word(3'd3, 16'h8000, pick_weight(), 1'b0);
    send_word(3'(MAXF - 1), 16'h7FFF, 16'h0001, 1'b1);
    wait_for_results();
  endtask

  // Words beyond the active dimension are stored but never complete a sample
  task automatic test_index_beyond_active();
    set_dimension(4'd3);
    send_word(3'd5, 16'h1234, pick_weight(), 1'b0);
    send_word(3'd0, 16'h7FFF, pick_weight(), 1'b0);
    send_word(3'd1, 16'h8000, pick_weight(), 1'b0);
    send_word(3'd2, 16'hFFFF, 16'h8000, 1'b0);
    send_word(3'd6, 16'h8000, 16'hFFFF, 1'b1);
    wait_for_results();
  endtask

  // Smallest and largest dimensions, including register values outside 1..8
  task automatic test_dimension_limits();
    set_dimension(4'd1);
    send_word(3'd0, 16'h8000, 16'hFFFF, 1'b1);
    wait_for_results();
    set_dimension(4'd0);
    send_word(3'd0, 16'h7FFF, 16'h0000, 1'b0);
    send_word(3'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    wait_for_results();
    set_dimension(4'd15);
    send_word(3'd7, 16'h0080, 16'h00FF, 1'b1);
    wait_for_results();
  endtask

  // Shrink the dimension with sums pending, then confirm everything was cleared
  task automatic test_dimension_change();
    set_dimension(4'd8);
    send_word(3'd7, 16'h4000, 16'h4000, 1'b0);
    wait_for_results();
    set_dimension(4'd2);
    send_word(3'd4, 16'h0000, 16'h0000, 1'b1);
    wait_for_results();
    set_dimension(4'd8);
    send_word(3'd5, 16'h7FFF, 16'hFFFF, 1'b1);
    wait_for_results();
  endtask

  // Phases of random dimension: mostly complete samples, some noise and bare ends
  task automatic test_random_traffic();
    int start_count;
    int m;
    int kind;
    logic [wga_pkg::CFG_W-1:0] cfg;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      wait_for_results();
      case ($urandom_range(9))
        0: cfg = 4'd1;
        1, 2: cfg = 4'd8;
        3: cfg = 4'd0;
        4: cfg = 4'($urandom_range(15, 9));
        default: cfg = 4'($urandom_range(7, 2));
      endcase
      set_dimension(cfg);
      steady = ($urandom_range(4) == 0);
      m = dim_in_use();
      repeat ($urandom_range(6, 2)) begin
        kind = $urandom_range(19);
        if (kind < 14) begin
          // well-formed sample, occasionally leaving a feature stale
          for (int f = 0; f < m - 1; f++)
            if (!(feature_written[f] && $urandom_range(7) == 0))
              send_word(3'(f), pick_value(), pick_weight(), 1'b0);
          send_word(3'(m - 1), pick_value(), pick_weight(), $urandom_range(3) == 0);
        end else if (kind < 17) begin
          repeat ($urandom_range(6, 1))
            send_word(safe_index($urandom_range(MAXF - 1), m), pick_value(), pick_weight(),
                      $urandom_range(7) == 0);
        end else begin
          send_word(safe_index($urandom_range(MAXF - 1), m), pick_value(), pick_weight(), 1'b1);
        end
      end
      if ($urandom_range(2) != 0)
        send_word(safe_index($urandom_range(MAXF - 1), m), pick_value(), pick_weight(), 1'b1);
    end
    steady = 1'b0;
  endtask

  // Randomly stall the result channel
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= idle_gap();
    end
  end

  // Compare each accepted word against the oldest expected entry
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("unexpected entry: row %0d col %0d value %0d last %0b",
                   row, col, gram_value, last_entry);
        fail_count++;
      end else begin
        next_entry = expected_entries.pop_front();
        if (row !== next_entry.row || col !== next_entry.col ||
            gram_value !== next_entry.value || last_entry !== next_entry.last) begin
          if (fail_count < REPORT_LIMIT)
            $display("mismatch: expected (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
                     next_entry.row, next_entry.col, next_entry.value, next_entry.last,
                     row, col, gram_value, last_entry);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    feature_index = '0;
    feature_value = '0;
    sample_weight = '0;
    end_of_data   = 1'b0;
    dim_setting     = wga_pkg::CFG_RESET;
    feature_written = '0;
    for (int i = 0; i < MAXF; i++) begin
      feature_buf[i] = '0;
      for (int j = 0; j < MAXF; j++)
        pair_acc[i][j] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_full_dimension();
    test_index_beyond_active();
    test_dimension_limits();
    test_dimension_change();
    test_random_traffic();
    wait_for_results();

    if (fail_count == 0 && expected_entries.size() == 0) begin
      $display("weighted_gram_accumulate regression: pass");
    end else begin
      $display("weighted_gram_accumulate regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_TIME);
    $display("weighted_gram_accumulate regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
src/wga_pkg.sv
src/wga_front.sv
src/wga_queue.sv
src/wga_back.sv
src/weighted_gram_accumulate.sv
sim/testbench.sv
